@@ sv/key_value_header_deframer_defines.svh @@
// assertion macros used by the checker file
`ifndef KEY_VALUE_HEADER_DEFRAMER_DEFINES_SVH
`define KEY_VALUE_HEADER_DEFRAMER_DEFINES_SVH

// same-cycle implication, ignored while reset is high
`define KVHD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kvhd check failed");

// next-cycle implication, ignored while reset is high
`define KVHD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kvhd check failed");

`endif

@@ sv/kvhd_pkg.sv @@
`timescale 1ns / 1ps

package kvhd_pkg;

   localparam int DATA_W  = 8;
   localparam int KIND_W  = 3;
   localparam int PHASE_W = 3;

   // phase codes
   localparam logic [PHASE_W-1:0] PH_KEYLEN = 3'd0;
   localparam logic [PHASE_W-1:0] PH_KEY    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_VALLEN = 3'd2;
   localparam logic [PHASE_W-1:0] PH_VAL    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PAY    = 3'd4;

   // byte kind codes
   localparam logic [KIND_W-1:0] KIND_KEYLEN = 3'd0;
   localparam logic [KIND_W-1:0] KIND_KEY    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VALLEN = 3'd2;
   localparam logic [KIND_W-1:0] KIND_VAL    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_END    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PAY    = 3'd5;

   localparam logic [DATA_W-1:0] HDR_TERMINATOR = 8'd0;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              last_byte;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0] byte_kind;
      logic [DATA_W-1:0] byte_value;
      logic              field_done;
      logic              message_done;
      logic              truncated;
   } rsp_item_type;

endpackage

@@ sv/kvhd_ifs.sv @@
`timescale 1ns / 1ps

interface kvhd_req_if
   import kvhd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface kvhd_rsp_if
   import kvhd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] byte_kind;
   logic [DATA_W-1:0] byte_value;
   logic              field_done;
   logic              message_done;
   logic              truncated;

   modport source (output valid, output byte_kind, output byte_value, output field_done,
                   output message_done, output truncated, input ready);
   modport sink   (input valid, input byte_kind, input byte_value, input field_done,
                   input message_done, input truncated, output ready);
endinterface

@@ sv/kvhd_in_reg.sv @@
`timescale 1ns / 1ps

module kvhd_in_reg
   import kvhd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         hold_valid,
   output req_item_type hold_item,
   input  logic         advance
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign in_ready = !valid_ff || advance;
   assign take     = in_valid && in_ready;
   assign valid_in = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= in_item;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

@@ sv/kvhd_tagger.sv @@
`timescale 1ns / 1ps

module kvhd_tagger
   import kvhd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  req_item_type item,
   input  logic         advance,
   output rsp_item_type result
);

   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic [DATA_W-1:0]  left_ff;
   logic [DATA_W-1:0]  left_in;
   logic [PHASE_W-1:0] phase_step;
   logic [DATA_W-1:0]  left_step;
   logic [DATA_W-1:0]  left_dec;
   logic [KIND_W-1:0]  kind;
   logic               done;
   logic               trunc;

   assign left_dec = left_ff - 8'd1;

   always_comb begin
      phase_step = phase_ff;
      left_step  = left_ff;
      kind       = KIND_KEYLEN;
      done       = 1'b0;
      unique case (phase_ff)
         PH_KEY: begin
            kind      = KIND_KEY;
            left_step = left_dec;
            if (left_dec == '0) begin
               done       = 1'b1;
               phase_step = PH_VALLEN;
            end
         end
         PH_VALLEN: begin
            kind = KIND_VALLEN;
            if (item.data_byte == '0) begin
               // empty value completes on its length byte
               done       = 1'b1;
               phase_step = PH_KEYLEN;
            end else begin
               left_step  = item.data_byte;
               phase_step = PH_VAL;
            end
         end
         PH_VAL: begin
            kind      = KIND_VAL;
            left_step = left_dec;
            if (left_dec == '0) begin
               done       = 1'b1;
               phase_step = PH_KEYLEN;
            end
         end
         PH_PAY: begin
            kind = KIND_PAY;
         end
         default: begin
            // expect key length, also for the unused codes
            if (item.data_byte == HDR_TERMINATOR) begin
               kind       = KIND_END;
               phase_step = PH_PAY;
            end else begin
               kind       = KIND_KEYLEN;
               left_step  = item.data_byte;
               phase_step = PH_KEY;
            end
         end
      endcase
   end

   assign trunc = item.last_byte &&
                  (phase_step == PH_KEY || phase_step == PH_VALLEN || phase_step == PH_VAL);

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      if (advance) begin
         if (item.last_byte) begin
            phase_in = PH_KEYLEN;
            left_in  = '0;
         end else begin
            phase_in = phase_step;
            left_in  = left_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KEYLEN;
         left_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

   assign result.byte_kind    = kind;
   assign result.byte_value   = item.data_byte;
   assign result.field_done   = done;
   assign result.message_done = item.last_byte;
   assign result.truncated    = trunc;

endmodule

@@ sv/kvhd_out_reg.sv @@
`timescale 1ns / 1ps

module kvhd_out_reg
   import kvhd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_item,
   output logic         space,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign space    = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ sv/key_value_header_deframer.sv @@
`timescale 1ns / 1ps
// each byte is held in the input register, then tagged and loaded into the output register,
// which offers its result; a result waiting there can hold the next byte back
// throughput: 1 byte per cycle while results are taken, set by the phase update in the tagger
// while a finished result waits in the output register the input register still takes
// one byte, then holds off the sender until the result goes
// reset (synchronous, active high) empties both registers and sets the phase to expect key length

module key_value_header_deframer
   import kvhd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   kvhd_req_if.sink  req_chan,
   kvhd_rsp_if.source rsp_chan
);

   // input side bundled into one item
   req_item_type req_item;
   req_item_type hold_item;
   logic         hold_valid;

   // tag for the byte waiting in the input register
   rsp_item_type tag_item;
   rsp_item_type out_item;

   // handshake between the two registers
   logic advance;
   logic out_space;
   logic out_valid;

   assign req_item.data_byte = req_chan.data_byte;
   assign req_item.last_byte = req_chan.last_byte;

   // a byte moves on when the output register is free or is being emptied this cycle
   assign advance = hold_valid && out_space;

   kvhd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_item    (req_item),
      .hold_valid (hold_valid),
      .hold_item  (hold_item),
      .advance    (advance)
   );

   // phase and remaining-count state, stepped once per byte that moves on
   kvhd_tagger u_tagger (
      .clock   (clock),
      .reset   (reset),
      .item    (hold_item),
      .advance (advance),
      .result  (tag_item)
   );

   kvhd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_item (tag_item),
      .space     (out_space),
      .out_valid (out_valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   // result transfer
   assign rsp_chan.valid        = out_valid;
   assign rsp_chan.byte_kind    = out_item.byte_kind;
   assign rsp_chan.byte_value   = out_item.byte_value;
   assign rsp_chan.field_done   = out_item.field_done;
   assign rsp_chan.message_done = out_item.message_done;
   assign rsp_chan.truncated    = out_item.truncated;

endmodule

@@ sv/kvhd_checker.sv @@
`timescale 1ns / 1ps
`include "key_value_header_deframer_defines.svh"

module kvhd_checker
   import kvhd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [KIND_W-1:0] byte_kind,
   input logic [DATA_W-1:0] byte_value,
   input logic              field_done,
   input logic              message_done,
   input logic              truncated
);

   // a stalled result holds
   `KVHD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(byte_kind) && $stable(byte_value) && $stable(field_done) && $stable(message_done) && $stable(truncated))

   // truncation is only reported on the final byte
   `KVHD_ASSERT_NOW(a_trunc_last, clock, reset, rsp_valid && truncated, message_done)

   // terminator and payload bytes never close a field or a truncated message
   `KVHD_ASSERT_NOW(a_end_pay_clean, clock, reset, rsp_valid && (byte_kind == KIND_END || byte_kind == KIND_PAY), !field_done && !truncated)

   // the terminator is a zero byte
   `KVHD_ASSERT_NOW(a_end_zero, clock, reset, rsp_valid && byte_kind == KIND_END, byte_value == HDR_TERMINATOR)

endmodule

bind key_value_header_deframer kvhd_checker u_kvhd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .byte_kind    (rsp_chan.byte_kind),
   .byte_value   (rsp_chan.byte_value),
   .field_done   (rsp_chan.field_done),
   .message_done (rsp_chan.message_done),
   .truncated    (rsp_chan.truncated)
);
